// ===== hw/rtl/lens_warp_address_assert.svh =====
`ifndef LENS_WARP_ADDRESS_ASSERT_SVH
`define LENS_WARP_ADDRESS_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LWA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lens warp check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define LWA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lens warp check failed");

`endif

// ===== hw/rtl/lwa_pkg.sv =====
package lwa_pkg;

  localparam int FRAC_BITS = 8;

  localparam int RAD_W = 7;
  localparam int STR_W = 12;
  localparam int CTR_W = 13;
  localparam int WIN_W = 8;
  localparam int SRC_W = 14;
  localparam int CFG_W = 13;
  localparam int IDX_W = 2;

  localparam int DELTA_W = WIN_W + 1;
  localparam int D2_W    = 2 * RAD_W + 1;
  localparam int R2_W    = 2 * RAD_W;
  localparam int SQ_IN_W = R2_W + 2 * FRAC_BITS;
  localparam int ROOT_W  = SQ_IN_W / 2;
  localparam int M_W     = ROOT_W + 2;
  localparam int QUO_W   = M_W - 1;
  localparam int NUM_W   = RAD_W + M_W + FRAC_BITS;
  localparam int OX_W    = QUO_W + 1;
  localparam int PROD_W  = OX_W + STR_W;
  localparam int SX_W    = PROD_W - FRAC_BITS;
  localparam int BASE_W  = CTR_W + 1;
  localparam int BX_W    = CTR_W + 2 + FRAC_BITS;

  localparam int SRC_MAX = 2 ** (SRC_W - 1) - 1;
  localparam int SRC_MIN = -(2 ** (SRC_W - 1));

  typedef enum logic [IDX_W-1:0] {
    REG_RADIUS   = 2'd0,
    REG_STRENGTH = 2'd1,
    REG_CENTER_X = 2'd2,
    REG_CENTER_Y = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                      valid;
    logic                      ins;
    logic [WIN_W-1:0]          wx;
    logic [WIN_W-1:0]          wy;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic                      sgn_x;
    logic                      sgn_y;
  } side_t;

endpackage

// ===== hw/rtl/lwa_if.sv =====
interface lwa_in_if;
  import lwa_pkg::*;
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] win_x;
  logic [WIN_W-1:0] win_y;
  modport source (output valid, win_x, win_y, input ready);
  modport sink (input valid, win_x, win_y, output ready);
endinterface

interface lwa_out_if;
  import lwa_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SRC_W-1:0] src_x;
  logic signed [SRC_W-1:0] src_y;
  logic                    inside_lens;
  modport source (output valid, src_x, src_y, inside_lens, input ready);
  modport sink (input valid, src_x, src_y, inside_lens, output ready);
endinterface

// ===== hw/rtl/lens_warp_address.sv =====
// Lens warp source address generator. Takes one destination pixel position
// (win_x, win_y) per clock and returns the screen position to sample plus an
// inside_lens flag. Throughput is one request per clock while the result
// side does not stall; the result passes 35 register stages: one input
// stage, fifteen square root stages (one root bit each), sixteen divider
// stages (one quotient bit each), the strength multiply, the final add and
// the output register. A stall on the result side freezes the whole
// pipeline. Configuration registers are sampled along the pipeline, so write
// them only while no request is in flight.
module lens_warp_address (
  input  logic                       clk,
  input  logic                       rst_n,
  lwa_in_if.sink                     in_chan,
  lwa_out_if.source                  out_chan,
  input  logic                       cfg_we,
  input  logic [lwa_pkg::IDX_W-1:0]  cfg_index,
  input  logic [lwa_pkg::CFG_W-1:0]  cfg_wdata
);
  import lwa_pkg::*;

  `include "lens_warp_address_assert.svh"

  logic [RAD_W-1:0]        radius_r;
  logic signed [STR_W-1:0] strength_r;
  logic signed [CTR_W-1:0] center_x_r;
  logic signed [CTR_W-1:0] center_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= RAD_W'(40);
      strength_r <= STR_W'(256);
      center_x_r <= '0;
      center_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RADIUS:   radius_r   <= cfg_wdata[RAD_W-1:0];
        REG_STRENGTH: strength_r <= cfg_wdata[STR_W-1:0];
        REG_CENTER_X: center_x_r <= cfg_wdata[CTR_W-1:0];
        REG_CENTER_Y: center_y_r <= cfg_wdata[CTR_W-1:0];
      endcase
    end
  end

  logic en;
  logic out_v_r;

  assign en            = !out_v_r || out_chan.ready;
  assign in_chan.ready = en;

  // input stage
  side_t a_r;
  side_t a_nxt;

  always_comb begin
    a_nxt       = '0;
    a_nxt.valid = in_chan.valid;
    a_nxt.wx    = in_chan.win_x;
    a_nxt.wy    = in_chan.win_y;
    a_nxt.dx    = $signed({1'b0, in_chan.win_x}) - $signed({2'b00, radius_r});
    a_nxt.dy    = $signed({1'b0, in_chan.win_y}) - $signed({2'b00, radius_r});
    a_nxt.ins   = (in_chan.win_x < {radius_r, 1'b0}) && (in_chan.win_y < {radius_r, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.valid <= 1'b0;
    end else if (en) begin
      a_r <= a_nxt;
    end
  end

  // distance squared and the two radicands
  logic signed [2*DELTA_W-1:0] sqx;
  logic signed [2*DELTA_W-1:0] sqy;
  logic [D2_W-1:0]             d2;
  logic [R2_W-1:0]             r2;
  logic                        ins_a;
  logic [SQ_IN_W-1:0]          rad_s;
  logic [SQ_IN_W-1:0]          rad_q;
  side_t                       sq_in;

  assign sqx   = a_r.dx * a_r.dx;
  assign sqy   = a_r.dy * a_r.dy;
  assign d2    = D2_W'(sqx) + D2_W'(sqy);
  assign r2    = radius_r * radius_r;
  assign ins_a = a_r.ins && (d2 != '0) && (d2 <= {1'b0, r2});
  assign rad_s = ins_a ? {r2 - d2[R2_W-1:0], {(2*FRAC_BITS){1'b0}}} : '0;
  assign rad_q = ins_a ? {d2[R2_W-1:0], {(2*FRAC_BITS){1'b0}}} : '0;

  always_comb begin
    sq_in     = a_r;
    sq_in.ins = ins_a;
  end

  logic [ROOT_W-1:0] s_root;
  logic [ROOT_W-1:0] q_root;

  lwa_isqrt u_sqrt_s (.clk(clk), .en(en), .rad(rad_s), .root(s_root));
  lwa_isqrt u_sqrt_q (.clk(clk), .en(en), .rad(rad_q), .root(q_root));

  side_t sq_sb_r [ROOT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROOT_W; i++) sq_sb_r[i].valid <= 1'b0;
    end else if (en) begin
      sq_sb_r[0] <= sq_in;
      for (int i = 1; i < ROOT_W; i++) sq_sb_r[i] <= sq_sb_r[i-1];
    end
  end

  // displacement magnitude and divider numerators
  side_t                 sb_b;
  logic signed [M_W-1:0] m_b;
  logic [M_W-1:0]        m_abs;
  logic [DELTA_W-1:0]    adx;
  logic [DELTA_W-1:0]    ady;
  logic [NUM_W-1:0]      num_x;
  logic [NUM_W-1:0]      num_y;
  side_t                 dv_in;

  assign sb_b  = sq_sb_r[ROOT_W-1];
  assign m_b   = $signed(M_W'({radius_r, {FRAC_BITS{1'b0}}}))
               - $signed(M_W'(s_root)) - $signed(M_W'(q_root));
  assign m_abs = m_b[M_W-1] ? M_W'(-m_b) : M_W'(m_b);
  assign adx   = sb_b.dx[DELTA_W-1] ? DELTA_W'(-sb_b.dx) : DELTA_W'(sb_b.dx);
  assign ady   = sb_b.dy[DELTA_W-1] ? DELTA_W'(-sb_b.dy) : DELTA_W'(sb_b.dy);
  assign num_x = NUM_W'(adx[RAD_W-1:0] * m_abs[M_W-2:0]) << FRAC_BITS;
  assign num_y = NUM_W'(ady[RAD_W-1:0] * m_abs[M_W-2:0]) << FRAC_BITS;

  always_comb begin
    dv_in       = sb_b;
    dv_in.sgn_x = sb_b.dx[DELTA_W-1] ^ m_b[M_W-1];
    dv_in.sgn_y = sb_b.dy[DELTA_W-1] ^ m_b[M_W-1];
  end

  logic [QUO_W-1:0] quo_x;
  logic [QUO_W-1:0] quo_y;

  lwa_div u_div_x (.clk(clk), .en(en), .num(num_x), .den(q_root), .quo(quo_x));
  lwa_div u_div_y (.clk(clk), .en(en), .num(num_y), .den(q_root), .quo(quo_y));

  side_t dv_sb_r [QUO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUO_W; i++) dv_sb_r[i].valid <= 1'b0;
    end else if (en) begin
      dv_sb_r[0] <= dv_in;
      for (int i = 1; i < QUO_W; i++) dv_sb_r[i] <= dv_sb_r[i-1];
    end
  end

  // signed offset times strength
  side_t                  sb_c;
  logic signed [OX_W-1:0] ox;
  logic signed [OX_W-1:0] oy;

  assign sb_c = dv_sb_r[QUO_W-1];
  assign ox   = !sb_c.ins ? '0 : (sb_c.sgn_x ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x}));
  assign oy   = !sb_c.ins ? '0 : (sb_c.sgn_y ? -$signed({1'b0, quo_y}) : $signed({1'b0, quo_y}));

  side_t                    p_sb_r;
  logic signed [PROD_W-1:0] prod_x_r;
  logic signed [PROD_W-1:0] prod_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_sb_r.valid <= 1'b0;
    end else if (en) begin
      p_sb_r   <= sb_c;
      prod_x_r <= PROD_W'(ox) * PROD_W'(strength_r);
      prod_y_r <= PROD_W'(oy) * PROD_W'(strength_r);
    end
  end

  // scale down toward zero and add the window position
  logic signed [PROD_W-1:0] px_adj;
  logic signed [PROD_W-1:0] py_adj;
  logic signed [SX_W-1:0]   sx;
  logic signed [SX_W-1:0]   sy;
  logic signed [BASE_W-1:0] base_x;
  logic signed [BASE_W-1:0] base_y;
  logic signed [BX_W-1:0]   bx_nxt;
  logic signed [BX_W-1:0]   by_nxt;

  assign px_adj = prod_x_r + (prod_x_r[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
  assign py_adj = prod_y_r + (prod_y_r[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
  assign sx     = SX_W'(px_adj >>> 8);
  assign sy     = SX_W'(py_adj >>> 8);
  assign base_x = $signed(BASE_W'({1'b0, p_sb_r.wx})) + BASE_W'(center_x_r)
                - $signed(BASE_W'({1'b0, radius_r}));
  assign base_y = $signed(BASE_W'({1'b0, p_sb_r.wy})) + BASE_W'(center_y_r)
                - $signed(BASE_W'({1'b0, radius_r}));
  assign bx_nxt = (BX_W'(base_x) <<< FRAC_BITS) + BX_W'(sx);
  assign by_nxt = (BX_W'(base_y) <<< FRAC_BITS) + BX_W'(sy);

  side_t                  q_sb_r;
  logic signed [BX_W-1:0] bx_r;
  logic signed [BX_W-1:0] by_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_sb_r.valid <= 1'b0;
    end else if (en) begin
      q_sb_r <= p_sb_r;
      bx_r   <= bx_nxt;
      by_r   <= by_nxt;
    end
  end

  // drop fraction toward zero, then clamp
  localparam logic signed [BX_W-1:0] PIX_MAX = BX_W'(SRC_MAX);
  localparam logic signed [BX_W-1:0] PIX_MIN = BX_W'(SRC_MIN);
  localparam logic signed [BX_W-1:0] FRAC_M  = BX_W'(2 ** FRAC_BITS - 1);

  logic signed [BX_W-1:0]  pix_x;
  logic signed [BX_W-1:0]  pix_y;
  logic signed [SRC_W-1:0] src_x_nxt;
  logic signed [SRC_W-1:0] src_y_nxt;

  assign pix_x = (bx_r + (bx_r[BX_W-1] ? FRAC_M : BX_W'(0))) >>> FRAC_BITS;
  assign pix_y = (by_r + (by_r[BX_W-1] ? FRAC_M : BX_W'(0))) >>> FRAC_BITS;

  always_comb begin
    priority if (pix_x > PIX_MAX) src_x_nxt = SRC_W'(SRC_MAX);
    else if (pix_x < PIX_MIN)     src_x_nxt = SRC_W'(SRC_MIN);
    else                          src_x_nxt = pix_x[SRC_W-1:0];
    priority if (pix_y > PIX_MAX) src_y_nxt = SRC_W'(SRC_MAX);
    else if (pix_y < PIX_MIN)     src_y_nxt = SRC_W'(SRC_MIN);
    else                          src_y_nxt = pix_y[SRC_W-1:0];
  end

  logic signed [SRC_W-1:0] src_x_r;
  logic signed [SRC_W-1:0] src_y_r;
  logic                    ins_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= q_sb_r.valid;
      src_x_r <= src_x_nxt;
      src_y_r <= src_y_nxt;
      ins_r   <= q_sb_r.ins;
    end
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.src_x       = src_x_r;
  assign out_chan.src_y       = src_y_r;
  assign out_chan.inside_lens = ins_r;

  `LWA_ASSERT_NEXT(a_stall_holds_div, !en, $stable(dv_sb_r[0].valid))
  `LWA_ASSERT_NOW(a_inside_needs_radius, out_v_r && ins_r, radius_r != '0)
  `LWA_ASSERT_NOW(a_sqrt_bounded, sb_b.valid && sb_b.ins, s_root <= {radius_r, {FRAC_BITS{1'b0}}})
  `LWA_ASSERT_NOW(a_dist_min, sb_b.valid && sb_b.ins, q_root >= (ROOT_W'(1) << FRAC_BITS))

endmodule

// ===== hw/rtl/lwa_isqrt.sv =====
module lwa_isqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [lwa_pkg::SQ_IN_W-1:0]  rad,
  output logic [lwa_pkg::ROOT_W-1:0]   root
);
  import lwa_pkg::*;

  localparam int X_W = ROOT_W + 3;

  logic [X_W-1:0]     x_r [ROOT_W];
  logic [ROOT_W-1:0]  r_r [ROOT_W];
  logic [SQ_IN_W-1:0] n_r [ROOT_W];

  // one root bit per stage, two radicand bits brought down each time
  for (genvar k = 0; k < ROOT_W; k++) begin : g_st
    localparam int J = ROOT_W - 1 - k;
    logic [X_W-1:0]     x_i;
    logic [X_W-1:0]     x2;
    logic [X_W-1:0]     trial;
    logic [ROOT_W-1:0]  r_i;
    logic [SQ_IN_W-1:0] n_i;

    if (k == 0) begin : g_first
      assign x_i = '0;
      assign r_i = '0;
      assign n_i = rad;
    end else begin : g_next
      assign x_i = x_r[k-1];
      assign r_i = r_r[k-1];
      assign n_i = n_r[k-1];
    end

    assign x2    = {x_i[X_W-3:0], n_i[2*J+1 -: 2]};
    assign trial = {1'b0, r_i, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k] <= n_i;
        if (x2 >= trial) begin
          x_r[k] <= x2 - trial;
          r_r[k] <= {r_i[ROOT_W-2:0], 1'b1};
        end else begin
          x_r[k] <= x2;
          r_r[k] <= {r_i[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = r_r[ROOT_W-1];

endmodule

// ===== hw/rtl/lwa_div.sv =====
module lwa_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [lwa_pkg::NUM_W-1:0]  num,
  input  logic [lwa_pkg::ROOT_W-1:0] den,
  output logic [lwa_pkg::QUO_W-1:0]  quo
);
  import lwa_pkg::*;

  logic [NUM_W-1:0]  rem_r [QUO_W];
  logic [ROOT_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0]  quo_r [QUO_W];

  // restoring division, one quotient bit per stage, MSB first
  for (genvar k = 0; k < QUO_W; k++) begin : g_st
    localparam int B = QUO_W - 1 - k;
    logic [NUM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] den_i;
    logic [QUO_W-1:0]  quo_i;
    logic [NUM_W-1:0]  dsh;

    if (k == 0) begin : g_first
      assign rem_i = num;
      assign den_i = den;
      assign quo_i = '0;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign den_i = den_r[k-1];
      assign quo_i = quo_r[k-1];
    end

    assign dsh = NUM_W'(den_i) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_i;
        if (rem_i >= dsh) begin
          rem_r[k] <= rem_i - dsh;
          quo_r[k] <= quo_i | (QUO_W'(1) << B);
        end else begin
          rem_r[k] <= rem_i;
          quo_r[k] <= quo_i;
        end
      end
    end
  end

  assign quo = quo_r[QUO_W-1];

endmodule

// ===== dv/lwa_checker.sv =====
module lwa_checker
  import lwa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  lwa_in_if                in_mon,
  lwa_out_if               out_mon,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               fails,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [SRC_W-1:0] sx;
    logic signed [SRC_W-1:0] sy;
    logic                    ins;
  } src_addr_t;

  logic [RAD_W-1:0]        lens_radius;
  logic signed [STR_W-1:0] lens_strength;
  logic signed [CTR_W-1:0] lens_cx;
  logic signed [CTR_W-1:0] lens_cy;

  src_addr_t src_q[$];

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [SRC_W-1:0] to_pixel(longint v);
    longint p;
    p = v / (longint'(1) << FRAC_BITS);
    if (p < SRC_MIN) p = SRC_MIN;
    if (p > SRC_MAX) p = SRC_MAX;
    return p[SRC_W-1:0];
  endfunction

  function automatic src_addr_t warp_src(logic [WIN_W-1:0] wxi, logic [WIN_W-1:0] wyi);
    longint one, wx, wy, r, dx, dy, d2, r2, s, q, m, ox, oy, offx, offy, str;
    src_addr_t res;
    one = longint'(1) << FRAC_BITS;
    wx = wxi;
    wy = wyi;
    r = lens_radius;
    str = lens_strength;
    offx = 0;
    offy = 0;
    res.ins = 1'b0;
    if (wx < 2 * r && wy < 2 * r) begin
      dx = wx - r;
      dy = wy - r;
      d2 = dx * dx + dy * dy;
      r2 = r * r;
      if (d2 != 0 && d2 <= r2) begin
        s = root_floor((r2 - d2) << (2 * FRAC_BITS));
        q = root_floor(d2 << (2 * FRAC_BITS));
        m = r * one - s - q;
        ox = (dx * m * one) / q;
        oy = (dy * m * one) / q;
        offx = (ox * str) / 256;
        offy = (oy * str) / 256;
        res.ins = 1'b1;
      end
    end
    res.sx = to_pixel((wx + longint'(lens_cx) - r) * one + offx);
    res.sy = to_pixel((wy + longint'(lens_cy) - r) * one + offy);
    return res;
  endfunction

  assign pending = src_q.size();

  always @(posedge clk) begin
    src_addr_t want;
    if (!rst_n) begin
      lens_radius   <= 7'd40;
      lens_strength <= 12'sd256;
      lens_cx       <= '0;
      lens_cy       <= '0;
      fails         <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_RADIUS:   lens_radius   <= cfg_wdata[RAD_W-1:0];
          REG_STRENGTH: lens_strength <= cfg_wdata[STR_W-1:0];
          REG_CENTER_X: lens_cx       <= cfg_wdata[CTR_W-1:0];
          REG_CENTER_Y: lens_cy       <= cfg_wdata[CTR_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) src_q = {src_q, warp_src(in_mon.win_x, in_mon.win_y)};
      if (out_mon.valid && out_mon.ready) begin
        if (src_q.size() == 0) begin
          $display("%t: unexpected result sx=%0d sy=%0d ins=%0b", $time,
                   out_mon.src_x, out_mon.src_y, out_mon.inside_lens);
          fails <= fails + 1;
        end else begin
          want = src_q.pop_front();
          if (want.sx !== out_mon.src_x || want.sy !== out_mon.src_y ||
              want.ins !== out_mon.inside_lens) begin
            $display("%t: mismatch expected sx=%0d sy=%0d ins=%0b actual sx=%0d sy=%0d ins=%0b",
                     $time, want.sx, want.sy, want.ins,
                     out_mon.src_x, out_mon.src_y, out_mon.inside_lens);
            fails <= fails + 1;
          end
        end
      end
    end
  end
endmodule

// ===== dv/tb_lens_warp_address.sv =====
module tb_lens_warp_address;
  import lwa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN   = 40;
  localparam int WD_LIMIT = 3000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  int               fails;
  int               pending;
  int               tx_count;
  int               rx_count;
  int               quiet_cycles;
  int               hold_left;
  bit               held;
  bit               calm;
  int               cur_radius;

  lwa_in_if  in_chan();
  lwa_out_if out_chan();

  lens_warp_address dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  lwa_checker chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mon   (in_chan),
    .out_mon  (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .fails    (fails),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random back-pressure, one long hold-off once results are flowing
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      rx_count <= 0;
      hold_left <= 0;
      held <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) rx_count <= rx_count + 1;
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!held && rx_count == 200) begin
        out_chan.ready <= 1'b0;
        held <= 1'b1;
        hold_left <= 150;
      end else begin
        out_chan.ready <= calm || ($urandom_range(99) >= 33);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_pixel(int x, int y);
    while (!calm && $urandom_range(99) < 33) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.win_x <= x[WIN_W-1:0];
    in_chan.win_y <= y[WIN_W-1:0];
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    tx_count++;
    calm = (tx_count >= 700 && tx_count < 1000);
  endtask

  // drop valid, let the pipeline empty, then load a new lens
  task automatic load_lens(int r, int s, int cx, int cy);
    in_chan.valid <= 1'b0;
    while (rx_count != tx_count) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_RADIUS;   cfg_wdata <= r[CFG_W-1:0];  @(posedge clk);
    cfg_index <= REG_STRENGTH; cfg_wdata <= s[CFG_W-1:0];  @(posedge clk);
    cfg_index <= REG_CENTER_X; cfg_wdata <= cx[CFG_W-1:0]; @(posedge clk);
    cfg_index <= REG_CENTER_Y; cfg_wdata <= cy[CFG_W-1:0]; @(posedge clk);
    cfg_we <= 1'b0;
    cur_radius = r;
  endtask

  task automatic run_lens(int n);
    int r;
    int w;
    r = cur_radius;
    w = 2 * r;
    send_pixel(0, 0);
    send_pixel(r, r);
    send_pixel(w - 1, w - 1);
    send_pixel(r + 1, r);
    send_pixel(r, 0);
    send_pixel(w, r);
    send_pixel(255, 255);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 85)
        send_pixel($urandom_range(w - 1), $urandom_range(w - 1));
      else
        send_pixel($urandom_range(255), $urandom_range(255));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.win_x = '0;
    in_chan.win_y = '0;
    tx_count = 0;
    calm = 0;
    cur_radius = 40;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_lens(230);
    load_lens(127, 2047, 4095, -4096);
    run_lens(230);
    load_lens(1, -2048, -4096, 4095);
    run_lens(60);
    load_lens(127, -2048, -1, 1);
    run_lens(230);
    load_lens(64, 0, 100, -100);
    run_lens(230);
    load_lens($urandom_range(1, 127), $urandom_range(4095) - 2048,
              $urandom_range(8191) - 4096, $urandom_range(8191) - 4096);
    run_lens(230);
    load_lens(100, 1, -4096, 4095);
    run_lens(230);
    load_lens(2, 300, 7, -7);
    run_lens(150);
    in_chan.valid <= 1'b0;
    while (rx_count != tx_count) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lwa_pkg.sv
hw/rtl/lwa_if.sv
hw/rtl/lwa_isqrt.sv
hw/rtl/lwa_div.sv
hw/rtl/lens_warp_address.sv
dv/lwa_checker.sv
dv/tb_lens_warp_address.sv
